// ===== rtl/core/kie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kie_pkg
// Shared constants, types and saturating fixed-point helpers for the keypad
// expression evaluator.
// ----------------------------------------------------------------------------
package kie_pkg;

    localparam int VALUE_W     = 64;
    localparam int FRAC_BITS   = 16;
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int NUM_W       = VALUE_W + FRAC_BITS;
    localparam int ALU_CNT_W   = $clog2(NUM_W + 1);
    localparam int OP_W        = 3;
    localparam int KEY_W       = 4;
    localparam int DIGIT_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int PHASE_W     = 3;
    localparam int S_DATA_W    = ((DIGIT_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((VALUE_W + STATUS_W + PHASE_W + 7) / 8) * 8;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [OP_W-1:0]    op_t;

    localparam value_t VMAX    = {1'b0, {(VALUE_W - 1){1'b1}}};
    localparam value_t VMIN    = {1'b1, {(VALUE_W - 1){1'b0}}};
    localparam value_t DIG_LIM = VMAX >> FRAC_BITS;

    // operator codes
    localparam op_t OP_PLUS   = 3'd0;
    localparam op_t OP_MINUS  = 3'd1;
    localparam op_t OP_TIMES  = 3'd2;
    localparam op_t OP_DIVIDE = 3'd3;
    localparam op_t OP_OPEN   = 3'd4;

    // key codes
    localparam logic [KEY_W-1:0] KEY_DIGIT  = 4'd0;
    localparam logic [KEY_W-1:0] KEY_PLUS   = 4'd1;
    localparam logic [KEY_W-1:0] KEY_MINUS  = 4'd2;
    localparam logic [KEY_W-1:0] KEY_TIMES  = 4'd3;
    localparam logic [KEY_W-1:0] KEY_DIVIDE = 4'd4;
    localparam logic [KEY_W-1:0] KEY_OPEN   = 4'd5;
    localparam logic [KEY_W-1:0] KEY_CLOSE  = 4'd6;
    localparam logic [KEY_W-1:0] KEY_CLEAR  = 4'd7;
    localparam logic [KEY_W-1:0] KEY_NEGATE = 4'd8;
    localparam logic [KEY_W-1:0] KEY_EQUALS = 4'd9;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SYNTAX  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAULT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    // reduction reach
    localparam logic [1:0] LVL_MULDIV  = 2'd0;
    localparam logic [1:0] LVL_BRACKET = 2'd1;
    localparam logic [1:0] LVL_CLOSE   = 2'd2;
    localparam logic [1:0] LVL_ALL     = 2'd3;

    typedef enum logic [PHASE_W-1:0] {
        PH_CLEAR   = 3'd0,
        PH_OPERAND = 3'd1,
        PH_OPERATOR= 3'd2,
        PH_ERROR   = 3'd3,
        PH_OPENB   = 3'd4,
        PH_CLOSEB  = 3'd5,
        PH_NEG     = 3'd6
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_OPEN,
        S_DIG_MUL,
        S_DIG_ADD,
        S_RED_RD,
        S_RED_OP,
        S_RED_B,
        S_RED_A,
        S_RED_ALU,
        S_RED_END,
        S_EQ_SH,
        S_NEG_WR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        AL_IDLE,
        AL_MUL,
        AL_MFIN,
        AL_DIV,
        AL_DFIN
    } alu_state_t;

    typedef struct packed {
        logic   start;
        op_t    op;
        value_t a;
        value_t b;
    } alu_req_t;

    typedef struct packed {
        logic   done;
        value_t result;
    } alu_rsp_t;

    function automatic value_t mag_of(input value_t v);
        return v[VALUE_W-1] ? (value_t'(0) - v) : v;
    endfunction

    function automatic value_t from_mag(input logic neg, input logic ovf, input value_t lo);
        value_t lim;
        lim = neg ? VMIN : VMAX;
        if (ovf || (lo > lim))
            return neg ? VMIN : VMAX;
        return neg ? (value_t'(0) - lo) : lo;
    endfunction

    function automatic value_t sat_add(input value_t a, input value_t b);
        logic [VALUE_W:0] s;
        s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        if (s[VALUE_W] != s[VALUE_W-1])
            return s[VALUE_W] ? VMIN : VMAX;
        return s[VALUE_W-1:0];
    endfunction

    function automatic value_t sat_sub(input value_t a, input value_t b);
        logic [VALUE_W:0] s;
        s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
        if (s[VALUE_W] != s[VALUE_W-1])
            return s[VALUE_W] ? VMIN : VMAX;
        return s[VALUE_W-1:0];
    endfunction

    function automatic value_t sat_neg(input value_t a);
        return (a == VMIN) ? VMAX : (value_t'(0) - a);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kie_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kie_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/kie_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kie_alu
// Saturating fixed-point arithmetic: registered add and subtract, bit-serial
// multiply and restoring divide.
// ----------------------------------------------------------------------------
module kie_alu (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire kie_pkg::alu_req_t req,
    output kie_pkg::alu_rsp_t     rsp
);

    localparam int W  = kie_pkg::VALUE_W;
    localparam int F  = kie_pkg::FRAC_BITS;
    localparam int NW = kie_pkg::NUM_W;
    localparam int CW = kie_pkg::ALU_CNT_W;

    kie_pkg::alu_state_t state_reg, state_next;
    logic                done_reg, done_next;
    kie_pkg::value_t     res_reg, res_next;
    logic                neg_reg, neg_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    kie_pkg::value_t     hi_reg, hi_next;
    kie_pkg::value_t     lo_reg, lo_next;
    kie_pkg::value_t     mb_reg, mb_next;
    kie_pkg::value_t     rem_reg, rem_next;
    logic [NW-1:0]       num_reg, num_next;
    logic                ovf_reg, ovf_next;

    logic [W:0]   mul_sum;
    logic [2*W-1:0] prod;
    logic [W:0]   rem_sh;
    logic         rem_ge;

    assign mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mb_reg} : '0);
    assign prod    = {hi_reg, lo_reg};
    assign rem_sh  = {rem_reg, num_reg[NW-1]};
    assign rem_ge  = rem_sh >= {1'b0, mb_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kie_pkg::AL_IDLE: begin
                if (req.start && req.op == kie_pkg::OP_TIMES)
                    state_next = kie_pkg::AL_MUL;
                else if (req.start && req.op == kie_pkg::OP_DIVIDE)
                    state_next = kie_pkg::AL_DIV;
            end
            kie_pkg::AL_MUL: begin
                if (cnt_reg == CW'(W - 1))
                    state_next = kie_pkg::AL_MFIN;
            end
            kie_pkg::AL_DIV: begin
                if (cnt_reg == CW'(NW - 1))
                    state_next = kie_pkg::AL_DFIN;
            end
            kie_pkg::AL_MFIN: state_next = kie_pkg::AL_IDLE;
            kie_pkg::AL_DFIN: state_next = kie_pkg::AL_IDLE;
            default:          state_next = kie_pkg::AL_IDLE;
        endcase
    end

    always_comb begin
        done_next = 1'b0;
        res_next  = res_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        mb_next   = mb_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        ovf_next  = ovf_reg;
        case (state_reg)
            kie_pkg::AL_IDLE: begin
                if (req.start) begin
                    neg_next = req.a[W-1] ^ req.b[W-1];
                    mb_next  = kie_pkg::mag_of(req.b);
                    cnt_next = '0;
                    case (req.op)
                        kie_pkg::OP_PLUS: begin
                            res_next  = kie_pkg::sat_add(req.a, req.b);
                            done_next = 1'b1;
                        end
                        kie_pkg::OP_MINUS: begin
                            res_next  = kie_pkg::sat_sub(req.a, req.b);
                            done_next = 1'b1;
                        end
                        kie_pkg::OP_TIMES: begin
                            hi_next = '0;
                            lo_next = kie_pkg::mag_of(req.a);
                        end
                        kie_pkg::OP_DIVIDE: begin
                            num_next = NW'(kie_pkg::mag_of(req.a)) << F;
                            rem_next = '0;
                            lo_next  = '0;
                            ovf_next = 1'b0;
                        end
                        default: begin
                            res_next  = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            kie_pkg::AL_MUL: begin
                hi_next  = mul_sum[W:1];
                lo_next  = {mul_sum[0], lo_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
            end
            kie_pkg::AL_MFIN: begin
                res_next  = kie_pkg::from_mag(neg_reg, |prod[2*W-1:W+F], prod[W+F-1:F]);
                done_next = 1'b1;
            end
            kie_pkg::AL_DIV: begin
                rem_next = rem_ge ? W'(rem_sh - {1'b0, mb_reg}) : rem_sh[W-1:0];
                ovf_next = ovf_reg | lo_reg[W-1];
                lo_next  = {lo_reg[W-2:0], rem_ge};
                num_next = num_reg << 1;
                cnt_next = cnt_reg + 1'b1;
            end
            kie_pkg::AL_DFIN: begin
                res_next  = kie_pkg::from_mag(neg_reg, ovf_reg, lo_reg);
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kie_pkg::AL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        res_reg <= res_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        mb_reg  <= mb_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule
`default_nettype wire

// ===== rtl/core/keypad_infix_expression_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_infix_expression_evaluator
// Calculator key sequencer with value and operator stacks held in RAM.
// ----------------------------------------------------------------------------
// One key request is taken at a time and gives one result request. An
// operator key reduces stacked operators one at a time; the bit-serial
// multiply and divide unit sets the worst-case time per key. The stacks live
// in two RAMs with a registered read and are never cleared; only entries
// below the stack counts are read. A pending result is held in an output
// register, so the next key is taken while it waits.
// ----------------------------------------------------------------------------
module keypad_infix_expression_evaluator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [kie_pkg::S_DATA_W-1:0]  s_tdata,  // [3:0] digit
    input  wire logic [kie_pkg::KEY_W-1:0]     s_tuser,  // [3:0] mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [kie_pkg::M_DATA_W-1:0]  m_tdata   // display_value, status, entry_phase
);

    localparam int W  = kie_pkg::VALUE_W;
    localparam int F  = kie_pkg::FRAC_BITS;
    localparam int AW = kie_pkg::ADDR_W;
    localparam int CW = kie_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(kie_pkg::STACK_DEPTH);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    kie_pkg::state_t   state_reg, state_next;
    kie_pkg::phase_t   phase_reg, phase_next;
    kie_pkg::value_t   entry_reg, entry_next;
    kie_pkg::op_t      pending_reg, pending_next;
    logic [CW-1:0]     vcnt_reg, vcnt_next;
    logic [CW-1:0]     ocnt_reg, ocnt_next;
    kie_pkg::value_t   shown_reg, shown_next;
    logic [kie_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [kie_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [kie_pkg::DIGIT_W-1:0]  digit_reg, digit_next;
    kie_pkg::value_t   bval_reg, bval_next;
    kie_pkg::op_t      op_reg, op_next;
    logic              m_tvalid_reg, m_tvalid_next;
    kie_pkg::value_t   out_value_reg, out_value_next;
    logic [kie_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [kie_pkg::PHASE_W-1:0]  out_phase_reg, out_phase_next;

    logic              v_we;
    logic [AW-1:0]     v_waddr, v_raddr;
    kie_pkg::value_t   v_wdata, v_rdata;
    logic              o_we;
    logic [AW-1:0]     o_waddr, o_raddr;
    kie_pkg::op_t      o_wdata, o_rdata;

    kie_pkg::alu_req_t alu_req;
    kie_pkg::alu_rsp_t alu_rsp;

    logic              vfull, ofull, out_free;
    kie_pkg::op_t      key_op;
    logic [1:0]        lvl;
    logic [CW-1:0]     vcnt_m1, vcnt_m2, ocnt_m1;
    logic [W+3:0]      m10;
    kie_pkg::value_t   emag, dfix;

    assign vfull    = vcnt_reg == DEPTH_C;
    assign ofull    = ocnt_reg == DEPTH_C;
    assign out_free = !m_tvalid_reg || m_tready;
    assign key_op   = kie_pkg::OP_W'(key_reg - kie_pkg::KEY_PLUS);
    assign vcnt_m1  = vcnt_reg - 1'b1;
    assign vcnt_m2  = vcnt_reg - TWO_C;
    assign ocnt_m1  = ocnt_reg - 1'b1;
    assign emag     = kie_pkg::mag_of(entry_reg);
    assign m10      = ((W + 4)'(emag) << 3) + ((W + 4)'(emag) << 1);
    assign dfix     = (W'(digit_reg) > kie_pkg::DIG_LIM) ? kie_pkg::VMAX
                                                         : (W'(digit_reg) << F);

    always_comb begin
        case (key_reg)
            kie_pkg::KEY_PLUS, kie_pkg::KEY_MINUS:   lvl = kie_pkg::LVL_BRACKET;
            kie_pkg::KEY_TIMES, kie_pkg::KEY_DIVIDE: lvl = kie_pkg::LVL_MULDIV;
            kie_pkg::KEY_CLOSE:                      lvl = kie_pkg::LVL_CLOSE;
            default:                                 lvl = kie_pkg::LVL_ALL;
        endcase
    end

    assign v_raddr = (state_reg == kie_pkg::S_RED_B) ? vcnt_m2[AW-1:0] : vcnt_m1[AW-1:0];
    assign o_raddr = ocnt_m1[AW-1:0];

    kie_ram #(.WIDTH(W), .DEPTH(kie_pkg::STACK_DEPTH)) u_vstack (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    kie_ram #(.WIDTH(kie_pkg::OP_W), .DEPTH(kie_pkg::STACK_DEPTH)) u_ostack (
        .aclk  (aclk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    kie_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kie_pkg::S_IDLE: begin
                if (s_tvalid)
                    state_next = kie_pkg::S_DECODE;
            end
            kie_pkg::S_DECODE: begin
                state_next = kie_pkg::S_DONE;
                if (key_reg > kie_pkg::KEY_EQUALS) begin
                    state_next = kie_pkg::S_DONE;
                end else if (phase_reg == kie_pkg::PH_ERROR && key_reg != kie_pkg::KEY_CLEAR) begin
                    state_next = kie_pkg::S_DONE;
                end else begin
                    case (key_reg)
                        kie_pkg::KEY_DIGIT: begin
                            if (phase_reg == kie_pkg::PH_OPERATOR)
                                state_next = ofull ? kie_pkg::S_DONE : kie_pkg::S_DIG_MUL;
                            else if (phase_reg inside {kie_pkg::PH_CLEAR, kie_pkg::PH_OPERAND,
                                                       kie_pkg::PH_OPENB})
                                state_next = kie_pkg::S_DIG_MUL;
                        end
                        kie_pkg::KEY_PLUS, kie_pkg::KEY_MINUS, kie_pkg::KEY_TIMES,
                        kie_pkg::KEY_DIVIDE, kie_pkg::KEY_CLOSE, kie_pkg::KEY_EQUALS: begin
                            if (!(phase_reg inside {kie_pkg::PH_OPERATOR, kie_pkg::PH_OPENB,
                                                    kie_pkg::PH_CLEAR})
                                && (phase_reg == kie_pkg::PH_CLOSEB || !vfull))
                                state_next = kie_pkg::S_RED_RD;
                        end
                        kie_pkg::KEY_OPEN: begin
                            if (phase_reg == kie_pkg::PH_OPERATOR && !ofull)
                                state_next = kie_pkg::S_PUSH_OPEN;
                        end
                        kie_pkg::KEY_NEGATE: begin
                            if (phase_reg == kie_pkg::PH_OPERATOR && vcnt_reg != '0)
                                state_next = kie_pkg::S_NEG_WR;
                        end
                        default: state_next = kie_pkg::S_DONE;
                    endcase
                end
            end
            kie_pkg::S_PUSH_OPEN: state_next = kie_pkg::S_DONE;
            kie_pkg::S_DIG_MUL:   state_next = kie_pkg::S_DIG_ADD;
            kie_pkg::S_DIG_ADD:   state_next = kie_pkg::S_DONE;
            kie_pkg::S_RED_RD: begin
                state_next = (ocnt_reg == '0) ? kie_pkg::S_RED_END : kie_pkg::S_RED_OP;
            end
            kie_pkg::S_RED_OP: begin
                if (o_rdata == kie_pkg::OP_OPEN)
                    state_next = (lvl == kie_pkg::LVL_ALL) ? kie_pkg::S_DONE : kie_pkg::S_RED_END;
                else if (lvl == kie_pkg::LVL_MULDIV && o_rdata < kie_pkg::OP_TIMES)
                    state_next = kie_pkg::S_RED_END;
                else if (o_rdata > kie_pkg::OP_OPEN || vcnt_reg < TWO_C)
                    state_next = kie_pkg::S_DONE;
                else
                    state_next = kie_pkg::S_RED_B;
            end
            kie_pkg::S_RED_B: state_next = kie_pkg::S_RED_A;
            kie_pkg::S_RED_A: begin
                if (op_reg == kie_pkg::OP_DIVIDE && bval_reg == '0)
                    state_next = kie_pkg::S_DONE;
                else
                    state_next = kie_pkg::S_RED_ALU;
            end
            kie_pkg::S_RED_ALU: begin
                if (alu_rsp.done)
                    state_next = kie_pkg::S_RED_RD;
            end
            kie_pkg::S_RED_END: begin
                if (key_reg == kie_pkg::KEY_EQUALS && vcnt_reg != '0)
                    state_next = kie_pkg::S_EQ_SH;
                else
                    state_next = kie_pkg::S_DONE;
            end
            kie_pkg::S_EQ_SH:  state_next = kie_pkg::S_DONE;
            kie_pkg::S_NEG_WR: state_next = kie_pkg::S_DONE;
            kie_pkg::S_DONE: begin
                if (out_free)
                    state_next = kie_pkg::S_IDLE;
            end
            default: state_next = kie_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        phase_next      = phase_reg;
        entry_next      = entry_reg;
        pending_next    = pending_reg;
        vcnt_next       = vcnt_reg;
        ocnt_next       = ocnt_reg;
        shown_next      = shown_reg;
        status_next     = status_reg;
        key_next        = key_reg;
        digit_next      = digit_reg;
        bval_next       = bval_reg;
        op_next         = op_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_phase_next  = out_phase_reg;
        v_we            = 1'b0;
        v_waddr         = vcnt_reg[AW-1:0];
        v_wdata         = entry_reg;
        o_we            = 1'b0;
        o_waddr         = ocnt_reg[AW-1:0];
        o_wdata         = pending_reg;
        alu_req.start   = 1'b0;
        alu_req.op      = op_reg;
        alu_req.a       = v_rdata;
        alu_req.b       = bval_reg;
        case (state_reg)
            kie_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    key_next    = s_tuser;
                    digit_next  = s_tdata[kie_pkg::DIGIT_W-1:0];
                    status_next = kie_pkg::ST_OK;
                end
            end
            kie_pkg::S_DECODE: begin
                if (key_reg > kie_pkg::KEY_EQUALS) begin
                    status_next = kie_pkg::ST_OK;
                end else if (phase_reg == kie_pkg::PH_ERROR && key_reg != kie_pkg::KEY_CLEAR) begin
                    status_next = kie_pkg::ST_IGNORED;
                end else begin
                    case (key_reg)
                        kie_pkg::KEY_DIGIT: begin
                            if (phase_reg == kie_pkg::PH_OPERATOR) begin
                                if (ofull) begin
                                    status_next = kie_pkg::ST_FAULT;
                                    phase_next  = kie_pkg::PH_ERROR;
                                end else begin
                                    o_we      = 1'b1;
                                    ocnt_next = ocnt_reg + 1'b1;
                                end
                            end else if (!(phase_reg inside {kie_pkg::PH_CLEAR,
                                                            kie_pkg::PH_OPERAND,
                                                            kie_pkg::PH_OPENB})) begin
                                status_next = kie_pkg::ST_SYNTAX;
                                phase_next  = kie_pkg::PH_ERROR;
                            end
                        end
                        kie_pkg::KEY_PLUS, kie_pkg::KEY_MINUS, kie_pkg::KEY_TIMES,
                        kie_pkg::KEY_DIVIDE, kie_pkg::KEY_CLOSE, kie_pkg::KEY_EQUALS: begin
                            if (phase_reg == kie_pkg::PH_OPERATOR
                                && key_reg <= kie_pkg::KEY_DIVIDE) begin
                                pending_next = key_op;
                            end else if (phase_reg == kie_pkg::PH_OPERATOR
                                         || phase_reg == kie_pkg::PH_OPENB) begin
                                status_next = kie_pkg::ST_SYNTAX;
                                phase_next  = kie_pkg::PH_ERROR;
                            end else if (phase_reg != kie_pkg::PH_CLEAR
                                         && phase_reg != kie_pkg::PH_CLOSEB) begin
                                entry_next = '0;
                                if (vfull) begin
                                    status_next = kie_pkg::ST_FAULT;
                                    phase_next  = kie_pkg::PH_ERROR;
                                end else begin
                                    v_we      = 1'b1;
                                    vcnt_next = vcnt_reg + 1'b1;
                                end
                            end
                        end
                        kie_pkg::KEY_OPEN: begin
                            if (phase_reg == kie_pkg::PH_CLEAR || phase_reg == kie_pkg::PH_OPENB
                                || phase_reg == kie_pkg::PH_OPERATOR) begin
                                if (ofull) begin
                                    status_next = kie_pkg::ST_FAULT;
                                    phase_next  = kie_pkg::PH_ERROR;
                                end else begin
                                    o_we      = 1'b1;
                                    ocnt_next = ocnt_reg + 1'b1;
                                    if (phase_reg != kie_pkg::PH_OPERATOR) begin
                                        o_wdata    = kie_pkg::OP_OPEN;
                                        phase_next = kie_pkg::PH_OPENB;
                                    end
                                end
                            end else begin
                                status_next = kie_pkg::ST_SYNTAX;
                                phase_next  = kie_pkg::PH_ERROR;
                            end
                        end
                        kie_pkg::KEY_CLEAR: begin
                            if (phase_reg != kie_pkg::PH_CLEAR) begin
                                entry_next = '0;
                                vcnt_next  = '0;
                                ocnt_next  = '0;
                                shown_next = '0;
                                phase_next = kie_pkg::PH_CLEAR;
                            end
                        end
                        kie_pkg::KEY_NEGATE: begin
                            if (phase_reg == kie_pkg::PH_OPERAND || phase_reg == kie_pkg::PH_NEG) begin
                                entry_next = kie_pkg::sat_neg(entry_reg);
                                phase_next = kie_pkg::PH_NEG;
                            end else if (phase_reg != kie_pkg::PH_OPERATOR
                                         && phase_reg != kie_pkg::PH_CLEAR) begin
                                status_next = kie_pkg::ST_SYNTAX;
                                phase_next  = kie_pkg::PH_ERROR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            kie_pkg::S_PUSH_OPEN: begin
                if (ofull) begin
                    status_next = kie_pkg::ST_FAULT;
                    phase_next  = kie_pkg::PH_ERROR;
                end else begin
                    o_we       = 1'b1;
                    o_wdata    = kie_pkg::OP_OPEN;
                    ocnt_next  = ocnt_reg + 1'b1;
                    phase_next = kie_pkg::PH_OPENB;
                end
            end
            kie_pkg::S_DIG_MUL: begin
                entry_next = kie_pkg::from_mag(entry_reg[W-1], |m10[W+3:W], m10[W-1:0]);
            end
            kie_pkg::S_DIG_ADD: begin
                entry_next = kie_pkg::sat_add(entry_reg, dfix);
                shown_next = kie_pkg::sat_add(entry_reg, dfix);
                phase_next = kie_pkg::PH_OPERAND;
            end
            kie_pkg::S_RED_OP: begin
                op_next = o_rdata;
                if (o_rdata == kie_pkg::OP_OPEN) begin
                    if (lvl == kie_pkg::LVL_ALL) begin
                        status_next = kie_pkg::ST_FAULT;
                        phase_next  = kie_pkg::PH_ERROR;
                    end else if (lvl == kie_pkg::LVL_CLOSE) begin
                        ocnt_next = ocnt_m1;
                    end
                end else if (lvl == kie_pkg::LVL_MULDIV && o_rdata < kie_pkg::OP_TIMES) begin
                    op_next = o_rdata;
                end else if (o_rdata > kie_pkg::OP_OPEN || vcnt_reg < TWO_C) begin
                    status_next = kie_pkg::ST_FAULT;
                    phase_next  = kie_pkg::PH_ERROR;
                end
            end
            kie_pkg::S_RED_B: begin
                bval_next = v_rdata;
            end
            kie_pkg::S_RED_A: begin
                if (op_reg == kie_pkg::OP_DIVIDE && bval_reg == '0) begin
                    status_next = kie_pkg::ST_FAULT;
                    phase_next  = kie_pkg::PH_ERROR;
                end else begin
                    alu_req.start = 1'b1;
                end
            end
            kie_pkg::S_RED_ALU: begin
                if (alu_rsp.done) begin
                    v_we      = 1'b1;
                    v_waddr   = vcnt_m2[AW-1:0];
                    v_wdata   = alu_rsp.result;
                    vcnt_next = vcnt_m1;
                    ocnt_next = ocnt_m1;
                end
            end
            kie_pkg::S_RED_END: begin
                if (key_reg == kie_pkg::KEY_CLOSE) begin
                    phase_next = kie_pkg::PH_CLOSEB;
                end else if (key_reg == kie_pkg::KEY_EQUALS) begin
                    if (vcnt_reg == '0) begin
                        status_next = kie_pkg::ST_FAULT;
                        phase_next  = kie_pkg::PH_ERROR;
                    end
                end else begin
                    pending_next = key_op;
                    phase_next   = kie_pkg::PH_OPERATOR;
                end
            end
            kie_pkg::S_EQ_SH: begin
                shown_next = v_rdata;
                entry_next = '0;
                phase_next = kie_pkg::PH_OPERATOR;
            end
            kie_pkg::S_NEG_WR: begin
                v_we    = 1'b1;
                v_waddr = vcnt_m1[AW-1:0];
                v_wdata = kie_pkg::sat_neg(v_rdata);
            end
            kie_pkg::S_DONE: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_value_next  = shown_reg;
                    out_status_next = status_reg;
                    out_phase_next  = phase_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kie_pkg::S_IDLE;
            phase_reg    <= kie_pkg::PH_CLEAR;
            entry_reg    <= '0;
            pending_reg  <= kie_pkg::OP_PLUS;
            vcnt_reg     <= '0;
            ocnt_reg     <= '0;
            shown_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            entry_reg    <= entry_next;
            pending_reg  <= pending_next;
            vcnt_reg     <= vcnt_next;
            ocnt_reg     <= ocnt_next;
            shown_reg    <= shown_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        status_reg     <= status_next;
        key_reg        <= key_next;
        digit_reg      <= digit_next;
        bval_reg       <= bval_next;
        op_reg         <= op_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_phase_reg  <= out_phase_next;
    end

    assign s_tready = state_reg == kie_pkg::S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = kie_pkg::M_DATA_W'({out_phase_reg, out_status_reg, out_value_reg});

endmodule
`default_nettype wire
